### rtl/itvm_pkg.sv
// ----------------------------------------------------------------------------
// itvm_pkg: shared types and constants for the interval table value match
// Holds the request action codes, controller states, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package itvm_pkg;

   localparam int DATA_W     = 32;
   localparam int QNUM_W     = 32;
   localparam int INUM_W     = 6;
   localparam int ACTION_W   = 2;
   localparam int DEPTH_DEF  = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_PR_CHK,
      ST_PR_CMP,
      ST_LW_CHK,
      ST_LW_CMP,
      ST_RW_CHK,
      ST_RW_CMP,
      ST_EM_RD,
      ST_EM_OUT
   } state_type;

   typedef enum logic [1:0] {
      ADDR_INS,
      ADDR_MID,
      ADDR_PTR
   } addr_sel_type;

   typedef struct packed {
      logic         clear;
      logic         load_start;
      logic         query_start;
      logic         ins_shift;
      logic         ins_place;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         probe_mid;
      logic         go_right;
      logic         go_left;
      logic         hit;
      logic         lw_ext;
      logic         to_right;
      logic         rw_ext;
      logic         em_start;
      logic         em_emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic pos_zero;
      logic lo_gt;
      logic win_empty;
      logic holds;
      logic q_gt_lo;
      logic q_lt_hi;
      logic ptr_below_left;
      logic ptr_above_right;
      logic em_last;
      logic rsp_busy;
   } status_type;

endpackage

### rtl/itvm_datapath.sv
// ----------------------------------------------------------------------------
// itvm_datapath: interval storage, search indices and result register
// Keeps the sorted interval memories, the insertion and search pointers,
// the query counter and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
module itvm_datapath #(
   parameter int DEPTH = itvm_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  itvm_pkg::cmd_type                   cmd,
   output itvm_pkg::status_type                status,
   input  logic signed [itvm_pkg::DATA_W-1:0]  req_lower_bound,
   input  logic signed [itvm_pkg::DATA_W-1:0]  req_upper_bound,
   input  logic signed [itvm_pkg::DATA_W-1:0]  req_query_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [itvm_pkg::QNUM_W-1:0]         rsp_query_number,
   output logic [itvm_pkg::INUM_W-1:0]         rsp_interval_number,
   output logic                                rsp_last_match
);
   import itvm_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 2;

   logic signed [DATA_W-1:0] lows_mem  [DEPTH];
   logic signed [DATA_W-1:0] highs_mem [DEPTH];
   logic [IW-1:0]            orig_mem  [DEPTH];

   logic signed [DATA_W-1:0] rd_lo_ff, rd_hi_ff;
   logic [IW-1:0]            rd_org_ff;
   logic signed [DATA_W-1:0] new_lo_ff, new_hi_ff, q_ff;
   logic [CW-1:0]            count_ff, pos_ff;
   logic [QNUM_W-1:0]        qcount_ff;
   logic signed [SW-1:0]     left_ff, right_ff, mid_ff, ptr_ff, lmin_ff, rmax_ff;
   logic                     dir_ff;
   logic                     rsp_valid_ff, rsp_last_ff;
   logic [QNUM_W-1:0]        rsp_qn_ff;
   logic [INUM_W-1:0]        rsp_in_ff;

   logic signed [SW-1:0]     mid_c, fin_c;
   logic [IW-1:0]            rd_addr;
   logic                     wr_en;
   logic signed [DATA_W-1:0] wr_lo, wr_hi;
   logic [IW-1:0]            wr_org;

   assign mid_c = (left_ff + right_ff) >>> 1;
   assign fin_c = (rmax_ff > mid_ff) ? rmax_ff : lmin_ff;

   always_comb begin
      case (cmd.addr_sel)
         ADDR_INS: rd_addr = IW'(pos_ff - CW'(1));
         ADDR_MID: rd_addr = IW'(mid_c);
         ADDR_PTR: rd_addr = IW'(ptr_ff);
         default:  rd_addr = IW'(ptr_ff);
      endcase
   end

   assign wr_en  = cmd.ins_shift | cmd.ins_place;
   assign wr_lo  = cmd.ins_shift ? rd_lo_ff  : new_lo_ff;
   assign wr_hi  = cmd.ins_shift ? rd_hi_ff  : new_hi_ff;
   assign wr_org = cmd.ins_shift ? rd_org_ff : IW'(count_ff);

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lows_mem[IW'(pos_ff)]  <= wr_lo;
         highs_mem[IW'(pos_ff)] <= wr_hi;
         orig_mem[IW'(pos_ff)]  <= wr_org;
      end
      if (cmd.rd_en) begin
         rd_lo_ff  <= lows_mem[rd_addr];
         rd_hi_ff  <= highs_mem[rd_addr];
         rd_org_ff <= orig_mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         qcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff  <= '0;
            qcount_ff <= '0;
         end
         if (cmd.ins_place) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.query_start && qcount_ff != '1) begin
            qcount_ff <= qcount_ff + QNUM_W'(1);
         end
         if (cmd.em_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         new_lo_ff <= req_lower_bound;
         new_hi_ff <= req_upper_bound;
         pos_ff    <= count_ff;
      end
      if (cmd.ins_shift) begin
         pos_ff <= pos_ff - CW'(1);
      end
      if (cmd.query_start) begin
         q_ff     <= req_query_value;
         left_ff  <= '0;
         right_ff <= $signed(SW'(count_ff)) - SW'(1);
      end
      if (cmd.probe_mid) begin
         mid_ff <= mid_c;
      end
      if (cmd.go_right) begin
         left_ff <= mid_ff + SW'(1);
      end
      if (cmd.go_left) begin
         right_ff <= mid_ff - SW'(1);
      end
      if (cmd.hit) begin
         lmin_ff <= mid_ff;
         rmax_ff <= mid_ff;
         ptr_ff  <= mid_ff - SW'(1);
      end
      if (cmd.lw_ext) begin
         lmin_ff <= ptr_ff;
         ptr_ff  <= ptr_ff - SW'(1);
      end
      if (cmd.to_right) begin
         ptr_ff <= mid_ff + SW'(1);
      end
      if (cmd.rw_ext) begin
         rmax_ff <= ptr_ff;
         ptr_ff  <= ptr_ff + SW'(1);
      end
      if (cmd.em_start) begin
         ptr_ff <= mid_ff;
         dir_ff <= 1'b0;
      end
      if (cmd.em_emit) begin
         rsp_qn_ff   <= qcount_ff;
         rsp_in_ff   <= INUM_W'(rd_org_ff) + INUM_W'(1);
         rsp_last_ff <= (ptr_ff == fin_c);
         // walk down to the left end first, then jump right of the hit
         if (dir_ff) begin
            ptr_ff <= ptr_ff + SW'(1);
         end else if (ptr_ff > lmin_ff) begin
            ptr_ff <= ptr_ff - SW'(1);
         end else begin
            ptr_ff <= mid_ff + SW'(1);
            dir_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      status.full            = (count_ff == CW'(DEPTH));
      status.pos_zero        = (pos_ff == '0);
      status.lo_gt           = (rd_lo_ff > new_lo_ff);
      status.win_empty       = (left_ff > right_ff);
      status.holds           = (q_ff > rd_lo_ff) && (q_ff < rd_hi_ff);
      status.q_gt_lo         = (q_ff > rd_lo_ff);
      status.q_lt_hi         = (q_ff < rd_hi_ff);
      status.ptr_below_left  = (ptr_ff < left_ff);
      status.ptr_above_right = (ptr_ff > right_ff);
      status.em_last         = (ptr_ff == fin_c);
      status.rsp_busy        = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_query_number    = rsp_qn_ff;
   assign rsp_interval_number = rsp_in_ff;
   assign rsp_last_match      = rsp_last_ff;

endmodule

### rtl/itvm_controller.sv
// ----------------------------------------------------------------------------
// itvm_controller: sequencing state machine
// Steps insertion, binary search, neighbour scans and result emission.
// ----------------------------------------------------------------------------
module itvm_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [itvm_pkg::ACTION_W-1:0]     req_action,
   output logic                              req_stall,
   input  itvm_pkg::status_type              status,
   output itvm_pkg::cmd_type                 cmd
);
   import itvm_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = ADDR_PTR;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_LOAD: begin
                     if (!status.full) begin
                        cmd.load_start = 1'b1;
                        state_in       = ST_INS_CHK;
                     end
                  end
                  ACT_QUERY: begin
                     cmd.query_start = 1'b1;
                     state_in        = ST_PR_CHK;
                  end
                  ACT_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_INS_CHK: begin
            if (status.pos_zero) begin
               cmd.ins_place = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_INS;
               state_in     = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (status.lo_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = ST_INS_CHK;
            end else begin
               cmd.ins_place = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_PR_CHK: begin
            if (status.win_empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.probe_mid = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.addr_sel  = ADDR_MID;
               state_in      = ST_PR_CMP;
            end
         end
         ST_PR_CMP: begin
            if (status.holds) begin
               cmd.hit  = 1'b1;
               state_in = ST_LW_CHK;
            end else if (status.q_gt_lo) begin
               cmd.go_right = 1'b1;
               state_in     = ST_PR_CHK;
            end else if (status.q_lt_hi) begin
               cmd.go_left = 1'b1;
               state_in    = ST_PR_CHK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LW_CHK: begin
            if (status.ptr_below_left) begin
               cmd.to_right = 1'b1;
               state_in     = ST_RW_CHK;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_LW_CMP;
            end
         end
         ST_LW_CMP: begin
            if (status.holds) begin
               cmd.lw_ext = 1'b1;
               state_in   = ST_LW_CHK;
            end else begin
               cmd.to_right = 1'b1;
               state_in     = ST_RW_CHK;
            end
         end
         ST_RW_CHK: begin
            if (status.ptr_above_right) begin
               cmd.em_start = 1'b1;
               state_in     = ST_EM_RD;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_RW_CMP;
            end
         end
         ST_RW_CMP: begin
            if (status.holds) begin
               cmd.rw_ext = 1'b1;
               state_in   = ST_RW_CHK;
            end else begin
               cmd.em_start = 1'b1;
               state_in     = ST_EM_RD;
            end
         end
         ST_EM_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (!status.rsp_busy) begin
               cmd.em_emit = 1'b1;
               state_in    = status.em_last ? ST_IDLE : ST_EM_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/interval_table_value_match_core.sv
// ----------------------------------------------------------------------------
// interval_table_value_match_core: sorted interval table with value search
// A load holds req_stall while larger entries shift up and the new one is
// placed; a query holds it through the binary-search probes (at most 6 at
// DEPTH 32), the neighbour walks to each side and the emission of each
// result, which rsp_stall can hold back.
// One request in flight at a time; the single memory read port sets the pace.
// Reset clears the entry and query counts; table contents are not cleared.
// ----------------------------------------------------------------------------
module interval_table_value_match_core #(
   parameter int DEPTH = itvm_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [itvm_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [itvm_pkg::DATA_W-1:0]  req_lower_bound,
   input  logic signed [itvm_pkg::DATA_W-1:0]  req_upper_bound,
   input  logic signed [itvm_pkg::DATA_W-1:0]  req_query_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [itvm_pkg::QNUM_W-1:0]         rsp_query_number,
   output logic [itvm_pkg::INUM_W-1:0]         rsp_interval_number,
   output logic                                rsp_last_match
);
   import itvm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: one request at a time, stall the request side while busy
   itvm_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: hold the table, walk the search and drive the result register
   itvm_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_lower_bound     (req_lower_bound),
      .req_upper_bound     (req_upper_bound),
      .req_query_value     (req_query_value),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_query_number    (rsp_query_number),
      .rsp_interval_number (rsp_interval_number),
      .rsp_last_match      (rsp_last_match)
   );

endmodule

### tb/tb_interval_table_value_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_table_value_match_core: self-checking bench for the interval core
// Loads intervals, clears and queries them under random idling on both
// channels, predicts every match in a local sorted-table model and compares
// each response field by field in the order the matches were predicted.
// ----------------------------------------------------------------------------
module tb_interval_table_value_match_core;
   import itvm_pkg::*;

   localparam int DEPTH = 32;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [QNUM_W-1:0] query_number;
      logic [INUM_W-1:0] interval_number;
      logic              last_match;
   } match_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ACTION_W-1:0] req_action = ACT_LOAD;
   logic signed [DATA_W-1:0] req_lower_bound = '0;
   logic signed [DATA_W-1:0] req_upper_bound = '0;
   logic signed [DATA_W-1:0] req_query_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [QNUM_W-1:0] rsp_query_number;
   logic [INUM_W-1:0] rsp_interval_number;
   logic rsp_last_match;

   interval_table_value_match_core #(.DEPTH(DEPTH)) dut (.*);

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Local copy of the sorted table
   logic signed [DATA_W-1:0] tbl_lo [DEPTH];
   logic signed [DATA_W-1:0] tbl_hi [DEPTH];
   logic [4:0]               tbl_org [DEPTH];
   int unsigned              tbl_count = 0;
   logic [QNUM_W-1:0]        queries_seen = '0;

   match_type pending_matches[$];
   int        mismatch_count = 0;
   int        match_count = 0;
   int        request_count = 0;
   bit        hold_off = 1'b0;

   function automatic bit covers(int p, logic signed [DATA_W-1:0] v);
      return v > tbl_lo[p] && v < tbl_hi[p];
   endfunction

   function automatic void push_match(int p, logic [QNUM_W-1:0] qn);
      match_type m;
      m.query_number    = qn;
      m.interval_number = INUM_W'(tbl_org[p]) + 1'b1;
      m.last_match      = 1'b0;
      pending_matches.insert(pending_matches.size(), m);
   endfunction

   // Predict the effect of one accepted request
   function automatic void predict_request(logic [1:0] act, logic signed [DATA_W-1:0] lo,
                                           logic signed [DATA_W-1:0] hi,
                                           logic signed [DATA_W-1:0] qv);
      int p, left, right, mid, l, r, found;
      found = 0;
      if (act == ACT_CLEAR) begin
         tbl_count = 0;
         queries_seen = '0;
      end else if (act == ACT_LOAD) begin
         if (tbl_count < DEPTH) begin
            p = tbl_count;
            while (p > 0 && tbl_lo[p-1] > lo) begin
               tbl_lo[p] = tbl_lo[p-1];
               tbl_hi[p] = tbl_hi[p-1];
               tbl_org[p] = tbl_org[p-1];
               p--;
            end
            tbl_lo[p] = lo;
            tbl_hi[p] = hi;
            tbl_org[p] = 5'(tbl_count);
            tbl_count++;
         end
      end else if (act == ACT_QUERY) begin
         if (queries_seen != '1) queries_seen++;
         left = 0;
         right = int'(tbl_count) - 1;
         while (left <= right) begin
            mid = (left + right) / 2;
            if (covers(mid, qv)) begin
               push_match(mid, queries_seen);
               found++;
               l = mid - 1;
               r = mid + 1;
               while (l >= left && covers(l, qv)) begin
                  push_match(l, queries_seen);
                  found++;
                  l--;
               end
               while (r <= right && covers(r, qv)) begin
                  push_match(r, queries_seen);
                  found++;
                  r++;
               end
               break;
            end else if (qv > tbl_lo[mid]) begin
               left = mid + 1;
            end else if (qv < tbl_hi[mid]) begin
               right = mid - 1;
            end else begin
               break;
            end
         end
         if (found > 0) begin
            pending_matches[pending_matches.size() - 1].last_match = 1'b1;
         end
      end
   endfunction

   // Send one request, then hold it until accepted
   task automatic send_request(logic [1:0] act, logic signed [DATA_W-1:0] lo,
                               logic signed [DATA_W-1:0] hi,
                               logic signed [DATA_W-1:0] qv, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4));
      repeat (gap) @(negedge clock);
      req_valid = 1'b1;
      req_action = act;
      req_lower_bound = lo;
      req_upper_bound = hi;
      req_query_value = qv;
      do @(posedge clock); while (req_stall);
      predict_request(act, lo, hi, qv);
      request_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Response checker
   always @(posedge clock) begin
      match_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         match_count++;
         if (pending_matches.size() == 0) begin
            $error("unexpected response qn=%0d in=%0d", rsp_query_number,
                   rsp_interval_number);
            mismatch_count++;
         end else begin
            e = pending_matches.pop_front();
            if (rsp_query_number !== e.query_number) begin
               $error("query_number expected %0d actual %0d", e.query_number,
                      rsp_query_number);
               mismatch_count++;
            end
            if (rsp_interval_number !== e.interval_number) begin
               $error("interval_number expected %0d actual %0d", e.interval_number,
                      rsp_interval_number);
               mismatch_count++;
            end
            if (rsp_last_match !== e.last_match) begin
               $error("last_match expected %0d actual %0d", e.last_match,
                      rsp_last_match);
               mismatch_count++;
            end
         end
      end
   end

   // Receiver idling: draw a wait for each response, hold off while asked to
   initial begin
      int idle_cycles;
      @(negedge clock);
      forever begin
         idle_cycles = $urandom_range(0, 4);
         while (hold_off || idle_cycles > 0) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
            if (idle_cycles > 0) idle_cycles--;
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic wait_drained();
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (8 * DEPTH + 80) @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] rand_word();
      return $urandom();
   endfunction

   function automatic logic signed [DATA_W-1:0] near(int c, int s);
      return c + $urandom_range(0, 2 * s) - s;
   endfunction

   // Directed: extremes, overlaps, empty and inverted intervals, spare code
   task automatic test_directed();
      send_request(ACT_QUERY, 0, 0, 0);                  // empty table
      send_request(ACT_LOAD, 32'sh8000_0000, 32'sh7fff_ffff, 0);
      send_request(ACT_LOAD, -10, 10, 0);
      send_request(ACT_LOAD, -5, 20, 0);
      send_request(ACT_LOAD, -10, 3, 0);                 // equal lower bound
      send_request(ACT_LOAD, 7, 7, 0);                   // empty interval
      send_request(ACT_LOAD, 40, 30, 0);                 // inverted interval
      send_request(ACT_QUERY, 0, 0, 0);
      send_request(ACT_QUERY, 0, 0, 7);
      send_request(ACT_QUERY, 0, 0, 35);
      send_request(ACT_QUERY, 0, 0, 32'sh7fff_ffff);
      send_request(ACT_QUERY, 0, 0, 32'sh8000_0000);
      send_request(ACT_QUERY, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_fffe);
      send_request(ACT_SPARE, -1, -1, 1);                // ignored
      send_request(ACT_QUERY, -1, -1, -1);
      send_request(ACT_CLEAR, -1, -1, -1);
      send_request(ACT_QUERY, 0, 0, 0);
      wait_drained();
   endtask

   // Fill past DEPTH with wide overlapping intervals, query for many matches
   task automatic test_full_table();
      send_request(ACT_CLEAR, 0, 0, 0);
      for (int i = 0; i < DEPTH + 3; i++)
         send_request(ACT_LOAD, near(-1000, 50), near(1000, 50), 0);
      for (int i = 0; i < 6; i++)
         send_request(ACT_QUERY, 0, 0, near(0, 900));
      wait_drained();
   endtask

   // Long receiver hold-off while the sender keeps offering queries
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 10; i++) send_request(ACT_QUERY, 0, 0, near(0, 500), 1);
      join
      wait_drained();  // sender pauses until every expected match has arrived
   endtask

   // Random sessions: clear, load small clustered tables, then query them
   task automatic test_random();
      int n, act;
      for (int s = 0; s < 20; s++) begin
         send_request(ACT_CLEAR, rand_word(), rand_word(), rand_word());
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_request(ACT_LOAD, rand_word(), rand_word(), rand_word());
            else
               send_request(ACT_LOAD, near(0, 300), near(200, 300), rand_word());
         end
         for (int i = 0; i < 6; i++) begin
            act = $urandom_range(0, 19);
            if (act == 0) send_request(ACT_SPARE, rand_word(), rand_word(), rand_word());
            else if (act == 1) send_request(ACT_QUERY, 0, 0, rand_word());
            else if (act == 2) send_request(ACT_LOAD, near(0, 300), near(200, 300), 0);
            else send_request(ACT_QUERY, rand_word(), rand_word(), near(100, 400));
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      test_random();
      $display("Covered %0d requests and %0d matches: extremes, full table,",
               request_count, match_count);
      $display("empty and inverted intervals, clears, spare code and long stalls.");
      if (mismatch_count == 0 && pending_matches.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
rtl/itvm_pkg.sv
rtl/itvm_datapath.sv
rtl/itvm_controller.sv
rtl/interval_table_value_match_core.sv
tb/tb_interval_table_value_match_core.sv
